// ===== rtl/core/fsrq_pkg.sv =====
`timescale 1ns / 1ps
package fsrq_pkg;

    localparam int LEN_W = 9;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CONSUME = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic REG_SLOTS_IN_USE  = 1'b0;
    localparam logic REG_MAX_FRAME_LEN = 1'b1;

    typedef struct packed {
        logic             accepted;
        logic [1:0]       status;
        logic             rd_ok;
        logic             empty;
        logic             fwd;
        logic [LEN_W-1:0] fwd_len;
        logic [3:0]       frames_held;
        logic [31:0]      drops;
    } stage_t;

endpackage

// ===== rtl/core/fsrq_ram.sv =====
`timescale 1ns / 1ps
module fsrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/fsrq_cfg.sv =====
`timescale 1ns / 1ps
module fsrq_cfg
    import fsrq_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int SLOT_BYTES = 256,
    parameter int NW = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [NW-1:0]    eff_slots,
    output logic [LEN_W-1:0] eff_max
);

    localparam int LEN_CAP = (SLOT_BYTES > 511) ? 511 : SLOT_BYTES;

    logic [4:0]       slots_reg, slots_next;
    logic [LEN_W-1:0] max_len_reg, max_len_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        slots_next   = slots_reg;
        max_len_next = max_len_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_SLOTS_IN_USE:  slots_next   = pwdata[4:0];
                REG_MAX_FRAME_LEN: max_len_next = pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg   <= 5'd16;
            max_len_reg <= 9'd256;
        end
        else
        begin
            slots_reg   <= slots_next;
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SLOTS_IN_USE:  prdata = {27'd0, slots_reg};
            REG_MAX_FRAME_LEN: prdata = {23'd0, max_len_reg};
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        if (32'(slots_reg) > 32'(NUM_SLOTS))
        begin
            eff_slots = NW'(NUM_SLOTS);
        end
        else if (slots_reg < 5'd2)
        begin
            eff_slots = NW'(2);
        end
        else
        begin
            eff_slots = NW'(slots_reg);
        end

        if (max_len_reg == '0)
        begin
            eff_max = LEN_W'(1);
        end
        else if (32'(max_len_reg) > 32'(LEN_CAP))
        begin
            eff_max = LEN_W'(LEN_CAP);
        end
        else
        begin
            eff_max = max_len_reg;
        end
    end

endmodule

// ===== rtl/core/fsrq_ctrl.sv =====
`timescale 1ns / 1ps
module fsrq_ctrl
    import fsrq_pkg::*;
#(
    parameter int SLOT_BYTES = 256,
    parameter int SW = 4,
    parameter int BW = 8,
    parameter int NW = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [1:0]       opcode,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic [7:0]       read_offset,
    input  logic [NW-1:0]    eff_slots,
    input  logic [LEN_W-1:0] eff_max,
    output logic             fram_we,
    output logic [SW+BW-1:0] fram_waddr,
    output logic [7:0]       fram_wdata,
    output logic             fram_re,
    output logic [SW+BW-1:0] fram_raddr,
    output logic             len_we,
    output logic [SW-1:0]    len_waddr,
    output logic [LEN_W-1:0] len_wdata,
    output logic             len_re,
    output logic [SW-1:0]    len_raddr,
    output stage_t           info
);

    logic [SW-1:0]    write_slot_reg, write_slot_next;
    logic [SW-1:0]    read_slot_reg, read_slot_next;
    logic [SW-1:0]    count_reg, count_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic             too_long_reg, too_long_next;
    logic [31:0]      drops_reg, drops_next;
    logic             store_ok;
    logic             full;

    function automatic logic [SW-1:0] step_slot(input logic [SW-1:0] idx,
                                                input logic [NW-1:0] n);
        logic [NW-1:0] inc;
        inc = NW'(idx) + NW'(1);
        return (inc >= n) ? '0 : SW'(inc);
    endfunction

    assign store_ok = !too_long_reg && (fill_reg < eff_max);
    assign full     = (NW'(count_reg) + NW'(1)) >= eff_slots;

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        too_long_next   = too_long_reg;
        drops_next      = drops_reg;
        fram_we         = 1'b0;
        fram_waddr      = {write_slot_reg, BW'(fill_reg)};
        fram_wdata      = data_byte;
        fram_re         = 1'b0;
        fram_raddr      = {read_slot_reg, BW'(read_offset)};
        len_we          = 1'b0;
        len_waddr       = write_slot_reg;
        len_wdata       = fill_reg + LEN_W'(1);
        info.accepted   = 1'b0;
        info.status     = ST_OK;
        info.rd_ok      = 1'b0;

        if (in_fire)
        begin
            unique case (opcode)
                OP_PUSH:
                begin
                    if (store_ok)
                    begin
                        fram_we   = 1'b1;
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    else
                    begin
                        too_long_next = 1'b1;
                    end
                    if (last_byte)
                    begin
                        if (!store_ok)
                        begin
                            info.status = ST_TOO_LONG;
                        end
                        else if (full)
                        begin
                            drops_next  = drops_reg + 32'd1;
                            info.status = ST_FULL;
                        end
                        else
                        begin
                            len_we          = 1'b1;
                            write_slot_next = step_slot(write_slot_reg, eff_slots);
                            count_next      = count_reg + SW'(1);
                            info.accepted   = 1'b1;
                        end
                        fill_next     = '0;
                        too_long_next = 1'b0;
                    end
                end
                OP_READ:
                begin
                    if (count_reg == '0)
                    begin
                        info.status = ST_EMPTY;
                    end
                    else
                    begin
                        fram_re       = 1'b1;
                        info.rd_ok    = 32'(read_offset) < 32'(SLOT_BYTES);
                        info.accepted = 1'b1;
                    end
                end
                OP_CONSUME:
                begin
                    if (count_reg == '0)
                    begin
                        info.status = ST_EMPTY;
                    end
                    else
                    begin
                        read_slot_next = step_slot(read_slot_reg, eff_slots);
                        count_next     = count_reg - SW'(1);
                        info.accepted  = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        len_re           = in_fire;
        len_raddr        = read_slot_next;
        info.empty       = (count_next == '0);
        info.fwd         = len_we && (write_slot_reg == read_slot_next);
        info.fwd_len     = len_wdata;
        info.frames_held = 4'(count_next);
        info.drops       = drops_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            count_reg      <= '0;
            fill_reg       <= '0;
            too_long_reg   <= 1'b0;
            drops_reg      <= '0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            too_long_reg   <= too_long_next;
            drops_reg      <= drops_next;
        end
    end

endmodule

// ===== rtl/core/frame_slot_ring_queue_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: stage 1 register with the memory reads, then the output register.
// Throughput: one item per cycle while the output side takes each result.
// Reset: control state clears at once; then a clearing pass over all NUM_SLOTS * 2^BW
// frame addresses (4096 by default) zeroes the frame and length memories; in_ready low.
// Configuration registers are writable throughout.
module frame_slot_ring_queue_unit
    import fsrq_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int SLOT_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  read_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  status,
    output logic [7:0]  read_data,
    output logic [8:0]  head_length,
    output logic [3:0]  frames_held,
    output logic [31:0] drop_count
);

    localparam int SW       = $clog2(NUM_SLOTS);
    localparam int NW       = $clog2(NUM_SLOTS + 1);
    localparam int ROW_SPAN = (SLOT_BYTES > 512) ? 512 : SLOT_BYTES;
    localparam int BW       = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1;
    localparam int AW       = SW + BW;
    localparam int FDEPTH   = NUM_SLOTS * (2 ** BW);

    logic [NW-1:0]    eff_slots;
    logic [LEN_W-1:0] eff_max;

    logic             in_fire;
    logic             c_fram_we, c_fram_re, c_len_we, c_len_re;
    logic [AW-1:0]    c_fram_waddr, c_fram_raddr;
    logic [7:0]       c_fram_wdata;
    logic [SW-1:0]    c_len_waddr, c_len_raddr;
    logic [LEN_W-1:0] c_len_wdata;
    stage_t           info;

    logic             fram_we, len_we;
    logic [AW-1:0]    fram_waddr;
    logic [7:0]       fram_wdata, fram_rdata;
    logic [SW-1:0]    len_waddr;
    logic [LEN_W-1:0] len_wdata, len_rdata;

    logic             clearing_reg, clearing_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;

    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;
    logic             accepted_reg;
    logic [1:0]       status_reg;
    logic [7:0]       read_data_reg;
    logic [8:0]       head_length_reg;
    logic [3:0]       frames_held_reg;
    logic [31:0]      drop_count_reg;

    fsrq_cfg #(
        .NUM_SLOTS  (NUM_SLOTS),
        .SLOT_BYTES (SLOT_BYTES),
        .NW         (NW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_slots (eff_slots),
        .eff_max   (eff_max)
    );

    fsrq_ctrl #(
        .SLOT_BYTES (SLOT_BYTES),
        .SW         (SW),
        .BW         (BW),
        .NW         (NW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .read_offset (read_offset),
        .eff_slots   (eff_slots),
        .eff_max     (eff_max),
        .fram_we     (c_fram_we),
        .fram_waddr  (c_fram_waddr),
        .fram_wdata  (c_fram_wdata),
        .fram_re     (c_fram_re),
        .fram_raddr  (c_fram_raddr),
        .len_we      (c_len_we),
        .len_waddr   (c_len_waddr),
        .len_wdata   (c_len_wdata),
        .len_re      (c_len_re),
        .len_raddr   (c_len_raddr),
        .info        (info)
    );

    // clearing pass owns the write ports; no transfers are taken meanwhile
    assign fram_we    = clearing_reg ? 1'b1 : c_fram_we;
    assign fram_waddr = clearing_reg ? clr_cnt_reg : c_fram_waddr;
    assign fram_wdata = clearing_reg ? 8'd0 : c_fram_wdata;
    assign len_we     = clearing_reg ? (32'(clr_cnt_reg) < 32'(NUM_SLOTS)) : c_len_we;
    assign len_waddr  = clearing_reg ? clr_cnt_reg[SW-1:0] : c_len_waddr;
    assign len_wdata  = clearing_reg ? '0 : c_len_wdata;

    fsrq_ram #(
        .WIDTH (8),
        .DEPTH (FDEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (fram_waddr),
        .wdata (fram_wdata),
        .re    (c_fram_re),
        .raddr (c_fram_raddr),
        .rdata (fram_rdata)
    );

    fsrq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (c_len_re),
        .raddr (c_len_raddr),
        .rdata (len_rdata)
    );

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) == 32'(FDEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
        end
    end

    assign out_load       = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !clearing_reg && (!s1_valid_reg || out_load);
    assign in_fire        = in_valid && in_ready;
    assign s1_valid_next  = in_fire || (s1_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= info;
        end
        if (out_load)
        begin
            accepted_reg    <= s1_reg.accepted;
            status_reg      <= s1_reg.status;
            read_data_reg   <= s1_reg.rd_ok ? fram_rdata : 8'd0;
            head_length_reg <= s1_reg.empty ? '0
                               : (s1_reg.fwd ? s1_reg.fwd_len : len_rdata);
            frames_held_reg <= s1_reg.frames_held;
            drop_count_reg  <= s1_reg.drops;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign status      = status_reg;
    assign read_data   = read_data_reg;
    assign head_length = head_length_reg;
    assign frames_held = frames_held_reg;
    assign drop_count  = drop_count_reg;

`ifndef SYNTH
    a_no_transfer_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !clearing_reg)
        else $error("input transfer taken during memory clearing pass");

    a_accept_is_ok : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> status == ST_OK)
        else $error("accepted result carries a failure status");

    a_data_needs_accept : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != 8'd0) |-> accepted)
        else $error("read data present on a result that was not accepted");

    a_s1_drains : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending result not moved to the output register");
`endif

endmodule
